// ===== rtl/core/bfd_pkg.sv =====
// Shared types and constants for the bunch filling distance block.
`timescale 1ns / 1ps

package bfd_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DIST_W      = 14;
    localparam int SUM_W       = 14;
    localparam int MAG_W       = 13;
    localparam int STEP_W      = $clog2(MAG_W + 1);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [1:0]        t_pair;

    // Command codes of an input beat
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic REG_BX_OFFSET    = 1'b0;
    localparam logic REG_BUCKET_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_HERE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage

// ===== rtl/core/bfd_ram.sv =====
// Bucket pattern memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bfd_ram (
    input  logic           i_clk,
    input  logic           i_we,
    input  bfd_pkg::t_addr i_waddr,
    input  bfd_pkg::t_pair i_wdata,
    input  bfd_pkg::t_addr i_raddr,
    output bfd_pkg::t_pair o_rdata
);
    import bfd_pkg::*;

    t_pair r_mem [RING_DEPTH];
    t_pair r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bfd_mod.sv =====
// Bit-serial reduction of a signed sum modulo the bucket count.
`timescale 1ns / 1ps

module bfd_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bfd_pkg::SUM_W-1:0]   i_sum,
    input  bfd_pkg::t_count             i_n,
    output bfd_pkg::t_mod_stat          o_stat,
    output bfd_pkg::t_addr              o_here
);
    import bfd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic              r_neg;
    logic [MAG_W-1:0]  r_mag;
    t_addr             r_rem;

    logic [SUM_W-1:0]  w_neg_sum;
    logic [MAG_W-1:0]  w_mag;
    t_count            w_trial;
    logic              w_ge;
    t_addr             w_rem;

    assign w_neg_sum = SUM_W'(~i_sum) + SUM_W'(1);
    assign w_mag     = i_sum[SUM_W-1] ? w_neg_sum[MAG_W-1:0] : i_sum[MAG_W-1:0];

    // shift in one dividend bit, subtract the divisor when it fits
    assign w_trial = {r_rem, r_mag[MAG_W-1]};
    assign w_ge    = (w_trial >= i_n);
    assign w_rem   = w_ge ? ADDR_W'(w_trial - i_n) : w_trial[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_sum[SUM_W-1];
            r_mag <= w_mag;
            r_rem <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            r_rem <= w_rem;
        end
    end

    // fold a negative remainder back into the ring
    assign o_here = (r_neg && r_rem != '0) ? ADDR_W'(i_n - {1'b0, r_rem}) : r_rem;

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== rtl/core/bunch_filling_distance_core.sv =====
// Top level of the bunch filling distance block.
`timescale 1ns / 1ps

// The block holds a ring of up to 4096 buckets, two bits each (beam one and
// beam two filled), in one synchronous memory. A load beat (cmd 0) writes one
// bucket. A query beat (cmd 1) maps its crossing to bucket (bx_offset +
// crossing_id - 1) mod n, where n is bucket_count saturated to 4096, then
// walks the ring backward one bucket per cycle from the bucket before it, one
// full turn at most, looking for the nearest beam-beam, beam-one-only and
// beam-two-only buckets. Distances run 1..n, or -1 when the kind is not
// found or n is zero. A query runs a bit-serial modulo reduction, one read
// of the queried bucket, then up to n memory reads; the walk stops early once
// all three kinds are found. The single read port of the pattern memory sets
// the walk rate. With n zero a query skips the reduction and the walk. The
// result sits in an output register, so the next beat is accepted while a
// result still waits to be taken. Buckets must be loaded before a query reads
// them; the memory has no reset. Write configuration only while the block is
// idle.

module bunch_filling_distance_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [12:0]                       i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [11:0]                       i_bucket_index,
    input  logic                              i_beam1_filled,
    input  logic                              i_beam2_filled,
    input  logic [11:0]                       i_crossing_id,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [bfd_pkg::DIST_W-1:0] o_dist_beam_beam,
    output logic signed [bfd_pkg::DIST_W-1:0] o_dist_beam_empty,
    output logic signed [bfd_pkg::DIST_W-1:0] o_dist_empty_beam,
    output logic                              o_is_beam_beam
);
    import bfd_pkg::*;

    // configuration
    logic signed [12:0] r_bx_offset;
    logic [12:0]        r_bucket_count;
    t_count             w_eff_n;

    // control and scan state
    t_state r_state, n_state;
    t_addr  r_k, n_k;
    t_count r_i, n_i;
    t_count r_bb, n_bb;
    t_count r_be, n_be;
    t_count r_eb, n_eb;
    logic   r_is_bb, n_is_bb;
    logic   r_o_valid, n_o_valid;

    // output payload
    logic signed [DIST_W-1:0] r_o_bb, r_o_be, r_o_eb;
    logic                     r_o_is_bb;

    logic             w_in_accept;
    logic             w_out_take;
    logic             w_out_load;
    logic             w_ram_we;
    t_addr            w_raddr;
    t_pair            w_rdata;
    logic [SUM_W-1:0] w_sum;
    logic             w_mod_start;
    t_mod_stat        w_mod_stat;
    t_addr            w_here;
    logic             w_b1, w_b2;

    // Step one bucket back around the ring
    function automatic t_addr f_prev(input t_addr a, input t_count n);
        f_prev = (a == '0) ? ADDR_W'(n - t_count'(1)) : a - ADDR_W'(1);
    endfunction

    // Zero means not found and reads out as -1
    function automatic logic signed [DIST_W-1:0] f_enc(input t_count d);
        f_enc = (d == '0) ? '1 : DIST_W'(d);
    endfunction

    assign w_eff_n = (r_bucket_count > 13'(RING_DEPTH)) ? t_count'(RING_DEPTH)
                                                       : t_count'(r_bucket_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bx_offset    <= '0;
            r_bucket_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BX_OFFSET:    r_bx_offset    <= i_cfg_data;
                REG_BUCKET_COUNT: r_bucket_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Crossing plus offset minus one, 14-bit two's complement
    assign w_sum = {r_bx_offset[12], r_bx_offset} + {2'b00, i_crossing_id} - SUM_W'(1);

    bfd_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_bucket_index),
        .i_wdata ({i_beam2_filled, i_beam1_filled}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bfd_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_sum   (w_sum),
        .i_n     (w_eff_n),
        .o_stat  (w_mod_stat),
        .o_here  (w_here)
    );

    assign w_in_accept = i_in_valid && (r_state == ST_IDLE);
    assign w_out_take  = r_o_valid && !i_out_stall;
    assign w_b1        = w_rdata[0];
    assign w_b2        = w_rdata[1];

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_i         = r_i;
        n_bb        = r_bb;
        n_be        = r_be;
        n_eb        = r_eb;
        n_is_bb     = r_is_bb;
        w_raddr     = r_k;
        w_ram_we    = 1'b0;
        w_mod_start = 1'b0;
        w_out_load  = 1'b0;
        n_o_valid   = w_out_take ? 1'b0 : r_o_valid;

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    if (i_cmd == CMD_LOAD) begin
                        w_ram_we = 1'b1;
                    end else if (w_eff_n == '0) begin
                        // no scheme loaded: answer none at once
                        n_bb    = '0;
                        n_be    = '0;
                        n_eb    = '0;
                        n_is_bb = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        w_mod_start = 1'b1;
                        n_state     = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (w_mod_stat.done) begin
                    w_raddr = w_here;
                    n_k     = f_prev(w_here, w_eff_n);
                    n_state = ST_HERE;
                end
            end
            ST_HERE: begin
                // data of the queried bucket; launch the first step back
                n_is_bb = w_b1 && w_b2;
                w_raddr = r_k;
                n_k     = f_prev(r_k, w_eff_n);
                n_i     = t_count'(1);
                n_bb    = '0;
                n_be    = '0;
                n_eb    = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // data here belongs to distance r_i; keep the first hit of each kind
                if (r_bb == '0 && w_b1 && w_b2) begin
                    n_bb = r_i;
                end
                if (r_be == '0 && w_b1 && !w_b2) begin
                    n_be = r_i;
                end
                if (r_eb == '0 && !w_b1 && w_b2) begin
                    n_eb = r_i;
                end
                w_raddr = r_k;
                n_k     = f_prev(r_k, w_eff_n);
                n_i     = r_i + t_count'(1);
                if (r_i == w_eff_n || (n_bb != '0 && n_be != '0 && n_eb != '0)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_o_valid || w_out_take) begin
                    w_out_load = 1'b1;
                    n_o_valid  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_i     <= n_i;
        r_bb    <= n_bb;
        r_be    <= n_be;
        r_eb    <= n_eb;
        r_is_bb <= n_is_bb;
        if (w_out_load) begin
            r_o_bb    <= f_enc(r_bb);
            r_o_be    <= f_enc(r_be);
            r_o_eb    <= f_enc(r_eb);
            r_o_is_bb <= r_is_bb;
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_dist_beam_beam  = r_o_bb;
    assign o_dist_beam_empty = r_o_be;
    assign o_dist_empty_beam = r_o_eb;
    assign o_is_beam_beam    = r_o_is_bb;

endmodule
